// ===== rtl/core/wlmpd_pkg.sv =====
package wlmpd_pkg;

  localparam int MAX_HALF_WINDOW = 64;
  localparam int SAMPLE_BITS     = 16;
  localparam int INDEX_BITS      = 24;
  localparam int POS_BITS        = INDEX_BITS + 1;
  localparam int DEPTH           = 2 * MAX_HALF_WINDOW;
  localparam int K_BITS          = 7;
  localparam int WIN_BITS        = $clog2(DEPTH + 1);
  localparam int CFG_IDX_BITS    = 1;

  localparam logic [K_BITS-1:0]     K_RESET      = K_BITS'(36);
  localparam logic [K_BITS-1:0]     K_MAX        = K_BITS'(MAX_HALF_WINDOW);
  localparam logic [INDEX_BITS-1:0] INDEX_MAX    = {INDEX_BITS{1'b1}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [K_BITS-1:0]             k_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HALF_WINDOW     = 1'b0,
    CFG_POSITION_OFFSET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic load;
  } row_ctrl_t;

endpackage

// ===== rtl/core/wlmpd_cell.sv =====
module wlmpd_cell (
  input  logic                clk,
  input  logic                shift,
  input  logic                load,
  input  wlmpd_pkg::sample_t  d_in,
  input  wlmpd_pkg::sample_t  center,
  input  logic                sel,
  input  logic                en,
  output wlmpd_pkg::sample_t  q,
  output wlmpd_pkg::sample_t  tap,
  output logic                flag
);

  wlmpd_pkg::sample_t q_r;
  wlmpd_pkg::sample_t q_nxt;
  logic               flag_r;
  logic               flag_nxt;

  always_comb begin
    q_nxt    = shift ? d_in : q_r;
    flag_nxt = load ? (en & (q_r > center)) : flag_r;
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    flag_r <= flag_nxt;
  end

  assign q    = q_r;
  assign tap  = q_r & {wlmpd_pkg::SAMPLE_BITS{sel}};
  assign flag = flag_r;

endmodule

// ===== rtl/core/wlmpd_row.sv =====
module wlmpd_row (
  input  logic                  clk,
  input  wlmpd_pkg::row_ctrl_t  ctrl,
  input  wlmpd_pkg::sample_t    din,
  input  wlmpd_pkg::k_t         k,
  output wlmpd_pkg::sample_t    center,
  output logic                  hit
);

  wlmpd_pkg::sample_t                 q   [wlmpd_pkg::DEPTH];
  wlmpd_pkg::sample_t                 tap [wlmpd_pkg::DEPTH];
  logic [wlmpd_pkg::DEPTH-1:0]        flags;
  logic [wlmpd_pkg::DEPTH-1:0]        sel;
  logic [wlmpd_pkg::DEPTH-1:0]        en;
  logic [wlmpd_pkg::WIN_BITS-1:0]     win;
  logic [wlmpd_pkg::WIN_BITS-1:0]     ctr;

  assign win = {k, 1'b0};
  assign ctr = wlmpd_pkg::WIN_BITS'(k) - wlmpd_pkg::WIN_BITS'(1);

  for (genvar o = 0; o < wlmpd_pkg::DEPTH; o++) begin : g_cell
    localparam logic [wlmpd_pkg::WIN_BITS-1:0] OIDX = wlmpd_pkg::WIN_BITS'(o);

    assign sel[o] = (OIDX == ctr);
    assign en[o]  = (OIDX < win) && (OIDX != ctr);

    wlmpd_cell u_cell (
      .clk    (clk),
      .shift  (ctrl.shift),
      .load   (ctrl.load),
      .d_in   ((o == 0) ? din : q[(o == 0) ? 0 : o - 1]),
      .center (center),
      .sel    (sel[o]),
      .en     (en[o]),
      .q      (q[o]),
      .tap    (tap[o]),
      .flag   (flags[o])
    );
  end

  always_comb begin
    center = '0;
    for (int o = 0; o < wlmpd_pkg::DEPTH; o++) begin
      center = center | tap[o];
    end
  end

  assign hit = |flags;

endmodule

// ===== rtl/core/window_local_max_peak_detector.sv =====
// Sliding-window local-maximum peak detector. One sample word is accepted per
// cycle while in_stall is low. A peak word is offered once the sample ending
// its window has been shifted into the row of 128 sample cells, every cell
// compared against the selected center with the per-cell flags registered,
// and the flags merged into the output register. A stalled output word holds
// the pipeline and then the input.
// Sample i is a peak when no sample in i-K .. i+K-1 is strictly greater (ties
// count). half_window (K, 0 reads as 1, above 64 saturates) and position_offset
// may only be written while idle.
module window_local_max_peak_detector (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  wlmpd_pkg::sample_t        in_sample,
  input  logic                      in_first_sample,
  input  logic                      in_last_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output wlmpd_pkg::pos_t           out_peak_position,
  output wlmpd_pkg::sample_t        out_peak_height,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  wlmpd_pkg::cfg_reg_t       cfg_index,
  input  logic [6:0]                cfg_data
);

  wlmpd_pkg::k_t        half_window_r, half_window_nxt;
  logic                 pos_offset_r, pos_offset_nxt;
  wlmpd_pkg::index_t    idx_r, idx_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  wlmpd_pkg::pos_t      s1_pos_r, s1_pos_nxt;
  logic                 s2_valid_r, s2_valid_nxt;
  wlmpd_pkg::pos_t      s2_pos_r, s2_pos_nxt;
  wlmpd_pkg::sample_t   s2_height_r, s2_height_nxt;
  logic                 out_valid_r, out_valid_nxt;
  wlmpd_pkg::pos_t      out_pos_r, out_pos_nxt;
  wlmpd_pkg::sample_t   out_height_r, out_height_nxt;

  wlmpd_pkg::k_t        k;
  wlmpd_pkg::index_t    m;
  wlmpd_pkg::index_t    min_m;
  logic                 accept;
  logic                 test;
  logic                 out_free;
  logic                 s1_adv;
  wlmpd_pkg::row_ctrl_t row_ctrl;
  wlmpd_pkg::sample_t   center;
  logic                 hit;

  always_comb begin
    if (half_window_r == '0) begin
      k = wlmpd_pkg::K_BITS'(1);
    end else if (half_window_r > wlmpd_pkg::K_MAX) begin
      k = wlmpd_pkg::K_MAX;
    end else begin
      k = half_window_r;
    end
  end

  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_adv   = ~s2_valid_r | out_free;
  assign in_stall = s1_valid_r & ~s1_adv;
  assign accept   = in_valid & ~in_stall;
  assign m        = in_first_sample ? '0 : idx_r;
  assign min_m    = wlmpd_pkg::INDEX_BITS'({k, 1'b0}) - wlmpd_pkg::INDEX_BITS'(1);
  assign test     = ~in_last_sample & (m >= min_m);

  assign row_ctrl.shift = accept;
  assign row_ctrl.load  = s1_adv;

  wlmpd_row u_row (
    .clk    (clk),
    .ctrl   (row_ctrl),
    .din    (in_sample),
    .k      (k),
    .center (center),
    .hit    (hit)
  );

  // config
  always_comb begin
    half_window_nxt = half_window_r;
    pos_offset_nxt  = pos_offset_r;
    if (cfg_valid) begin
      case (cfg_index)
        wlmpd_pkg::CFG_HALF_WINDOW:     half_window_nxt = cfg_data;
        wlmpd_pkg::CFG_POSITION_OFFSET: pos_offset_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // pipeline
  always_comb begin
    idx_nxt        = idx_r;
    s1_valid_nxt   = s1_valid_r;
    s1_pos_nxt     = s1_pos_r;
    s2_valid_nxt   = s2_valid_r;
    s2_pos_nxt     = s2_pos_r;
    s2_height_nxt  = s2_height_r;
    out_valid_nxt  = out_valid_r;
    out_pos_nxt    = out_pos_r;
    out_height_nxt = out_height_r;

    if (out_free) begin
      out_valid_nxt  = s2_valid_r & ~hit;
      out_pos_nxt    = s2_pos_r;
      out_height_nxt = s2_height_r;
    end

    if (s1_adv) begin
      s2_valid_nxt  = s1_valid_r;
      s2_pos_nxt    = s1_pos_r;
      s2_height_nxt = center;
      s1_valid_nxt  = 1'b0;
    end

    if (accept) begin
      idx_nxt      = (m == wlmpd_pkg::INDEX_MAX) ? m : m + wlmpd_pkg::INDEX_BITS'(1);
      s1_valid_nxt = test;
      s1_pos_nxt   = {1'b0, m} - wlmpd_pkg::POS_BITS'(k) + wlmpd_pkg::POS_BITS'(1)
                     + wlmpd_pkg::POS_BITS'(pos_offset_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= wlmpd_pkg::K_RESET;
      pos_offset_r  <= 1'b1;
      idx_r         <= '0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      half_window_r <= half_window_nxt;
      pos_offset_r  <= pos_offset_nxt;
      idx_r         <= idx_nxt;
      s1_valid_r    <= s1_valid_nxt;
      s2_valid_r    <= s2_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r     <= s1_pos_nxt;
    s2_pos_r     <= s2_pos_nxt;
    s2_height_r  <= s2_height_nxt;
    out_pos_r    <= out_pos_nxt;
    out_height_r <= out_height_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_peak_position = out_pos_r;
  assign out_peak_height   = out_height_r;

endmodule

// ===== tb/peak_checker.sv =====
`timescale 1ns / 100ps
module peak_checker
  import wlmpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_stall,
  input  sample_t in_sample,
  input  logic    in_first_sample,
  input  logic    in_last_sample,
  input  logic    out_valid,
  input  logic    out_stall,
  input  pos_t    out_peak_position,
  input  sample_t out_peak_height,
  input  logic    cfg_valid,
  input  logic    cfg_ready,
  input  cfg_reg_t cfg_index,
  input  logic [6:0] cfg_data,
  output int      peak_mismatches,
  output int      peaks_outstanding
);

  typedef struct {
    pos_t    position;
    sample_t height;
  } peak_t;

  sample_t window [DEPTH];
  index_t  next_index;
  k_t      half_window;
  logic    position_offset;
  peak_t   peaks_due[$];
  peak_t   want;
  int      mismatch_count = 0;

  // Window holds newest sample first; center i is tested when i+K-1 arrives.
  task automatic advance_window(input sample_t s, input logic first, input logic last);
    index_t  m;
    int      k;
    logic    is_peak;
    sample_t center;
    m = first ? '0 : next_index;
    if (half_window == 0) k = 1;
    else if (half_window > K_MAX) k = MAX_HALF_WINDOW;
    else k = int'(half_window);
    for (int j = DEPTH - 1; j > 0; j--) window[j] = window[j - 1];
    window[0] = s;
    next_index = (m < INDEX_MAX) ? m + 1'b1 : INDEX_MAX;
    if (last || m < index_t'(2 * k - 1)) return;
    center = window[k - 1];
    is_peak = 1'b1;
    for (int o = 0; o < 2 * k; o++) begin
      if (o != k - 1 && window[o] > center) is_peak = 1'b0;
    end
    if (is_peak)
      peaks_due.push_back('{pos_t'(m) - pos_t'(k - 1) + pos_t'(position_offset), center});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (window[j]) window[j] = '0;
      next_index = '0;
      half_window = K_RESET;
      position_offset = 1'b1;
      peaks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HALF_WINDOW) half_window = cfg_data;
        else if (cfg_index == CFG_POSITION_OFFSET) position_offset = cfg_data[0];
      end
      if (out_valid && !out_stall) begin
        if (peaks_due.size() == 0) begin
          $display("%0t unexpected peak word: expected none, got position %0d height %0d",
                   $time, out_peak_position, out_peak_height);
          mismatch_count++;
        end else begin
          want = peaks_due.pop_front();
          if (out_peak_position !== want.position) begin
            $display("%0t peak_position: expected %0d, got %0d",
                     $time, want.position, out_peak_position);
            mismatch_count++;
          end
          if (out_peak_height !== want.height) begin
            $display("%0t peak_height: expected %0d, got %0d",
                     $time, want.height, out_peak_height);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        advance_window(in_sample, in_first_sample, in_last_sample);
    end
    peak_mismatches <= mismatch_count;
    peaks_outstanding <= peaks_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import wlmpd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam sample_t SAMPLE_TOP    = sample_t'(16'h7FFF);
  localparam sample_t SAMPLE_BOTTOM = sample_t'(16'h8000);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  sample_t    in_sample = '0;
  logic       in_first_sample = 1'b0;
  logic       in_last_sample = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pos_t       out_peak_position;
  sample_t    out_peak_height;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_reg_t   cfg_index = CFG_HALF_WINDOW;
  logic [6:0] cfg_data = '0;

  int   peak_mismatches;
  int   peaks_outstanding;
  logic quiet = 1'b0;
  int   sent_count = 0;
  int   stall_hold = 0;
  int   idle_cycles = 0;
  sample_t walk_level = '0;

  int hw_list[9]  = '{1, 3, 64, 127, 36, 5, 2, 7, 0};
  int off_list[9] = '{1, 0, 1, 0, 1, 1, 0, 1, 0};

  always #2 clk = ~clk;

  window_local_max_peak_detector uut (.*);

  peak_checker checker_i (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t make_sample(input int style);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 6)) - 3);
      2: begin
        case ($urandom_range(0, 2))
          0: return SAMPLE_TOP;
          1: return SAMPLE_BOTTOM;
          default: return '0;
        endcase
      end
      default: begin
        walk_level = walk_level + sample_t'(int'($urandom_range(0, 400)) - 200);
        if ($urandom_range(0, 19) == 0) return SAMPLE_TOP;
        return walk_level;
      end
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input logic f, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_sample <= s;
    in_first_sample <= f;
    in_last_sample <= l;
    do @(posedge clk); while (in_stall);
    sent_count++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly whole records with random content; some run on without marks.
  task automatic stream_record(input int k);
    int   n;
    int   style;
    logic fresh;
    logic closed;
    logic f;
    logic l;
    if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * k);
    else n = $urandom_range(2 * k + 1, 3 * k + 8);
    style = $urandom_range(0, 3);
    fresh = $urandom_range(0, 9) != 0;
    closed = $urandom_range(0, 9) != 0;
    for (int i = 0; i < n; i++) begin
      f = fresh && i == 0;
      l = closed && i == n - 1;
      if ($urandom_range(0, 39) == 0) begin
        f = $urandom_range(0, 1);
        l = $urandom_range(0, 1);
      end
      send_sample(make_sample(style), f, l);
    end
  endtask

  // Nothing may be in flight before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (peaks_outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= !quiet && $urandom_range(0, 2) == 0;
      stall_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL window_local_max_peak_detector");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int keff;
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // half window zero acts as one; no first mark yet, so indices start at zero
    write_reg(CFG_HALF_WINDOW, 7'd0);
    write_reg(CFG_POSITION_OFFSET, {6'($urandom), 1'b0});
    send_sample(SAMPLE_TOP, 1'b0, 1'b0);
    send_sample(SAMPLE_BOTTOM, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(sample_t'(-1), 1'b0, 1'b0);
    send_sample(sample_t'(1), 1'b0, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0, 1'b0);
    send_sample(sample_t'(16'h5555), 1'b0, 1'b0);
    send_sample(sample_t'(16'hAAAA), 1'b0, 1'b0);
    send_sample(SAMPLE_BOTTOM, 1'b0, 1'b1);
    send_sample(sample_t'(100), 1'b1, 1'b1);
    send_sample(sample_t'(5), 1'b1, 1'b0);
    send_sample(sample_t'(6), 1'b0, 1'b1);
    send_sample(sample_t'(7), 1'b1, 1'b0);
    send_sample(sample_t'(7), 1'b0, 1'b0);
    send_sample(sample_t'(7), 1'b0, 1'b0);
    send_sample(sample_t'(7), 1'b0, 1'b1);
    send_sample(SAMPLE_BOTTOM, 1'b1, 1'b0);
    send_sample(SAMPLE_BOTTOM, 1'b0, 1'b0);
    send_sample(SAMPLE_BOTTOM, 1'b0, 1'b0);
    send_sample(SAMPLE_BOTTOM, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 9; p++) begin
      write_reg(CFG_HALF_WINDOW, 7'(hw_list[p]));
      write_reg(CFG_POSITION_OFFSET, {6'($urandom), 1'(off_list[p])});
      quiet = (p == 1 || p == 5);
      if (hw_list[p] == 0) keff = 1;
      else if (hw_list[p] > MAX_HALF_WINDOW) keff = MAX_HALF_WINDOW;
      else keff = hw_list[p];
      target = 50;
      sent_count = 0;
      while (sent_count < target) stream_record(keff);
      drain();
    end

    if (peak_mismatches == 0 && peaks_outstanding == 0) begin
      $display("PASS window_local_max_peak_detector");
    end else begin
      $display("FAIL window_local_max_peak_detector");
    end
    $finish;
  end

endmodule

// ===== window_local_max_peak_detector.f =====
rtl/core/wlmpd_pkg.sv
rtl/core/wlmpd_cell.sv
rtl/core/wlmpd_row.sv
rtl/core/window_local_max_peak_detector.sv
tb/peak_checker.sv
tb/tb_top.sv
